>>> hw/rtl/wfts_pkg.sv
// Package for the weighted fair task scheduler: codes, entry layout, FSM types.
// No dependencies; imported by every RTL module of the block.
package wfts_pkg;

    localparam int TASK_SLOTS_DEF   = 64;
    localparam int MAX_PRIORITY_DEF = 31;

    localparam int ID_W    = 6;
    localparam int PRIO_W  = 8;
    localparam int TICKS_W = 32;
    localparam int RT_W    = 64;
    localparam int OP_W    = 3;
    localparam int RES_W   = 3;

    typedef enum logic [OP_W-1:0] {
        OP_CREATE   = 3'd0,
        OP_SCHEDULE = 3'd1,
        OP_CHARGE   = 3'd2,
        OP_KILL     = 3'd3,
        OP_SHUTDOWN = 3'd4
    } op_t;

    typedef enum logic [RES_W-1:0] {
        RES_OK       = 3'd0,
        RES_BAD_PRIO = 3'd1,
        RES_FULL     = 3'd2,
        RES_BAD_ID   = 3'd3,
        RES_NONE     = 3'd4
    } res_t;

    typedef enum logic [1:0] {
        ENT_UNUSED = 2'd0,
        ENT_READY  = 2'd1,
        ENT_ZOMBIE = 2'd2
    } ent_st_t;

    typedef struct packed {
        ent_st_t           st;
        logic [PRIO_W-1:0] prio;
        logic [RT_W-1:0]   runtime;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_ENT_EXEC,
        ST_SH_RD,
        ST_SH_EXEC,
        ST_SC_RD,
        ST_SC_CHK,
        ST_SC_WAIT,
        ST_FIN
    } state_t;

    typedef enum logic [1:0] {
        VT_IDLE,
        VT_MUL_LO,
        VT_MUL_HI,
        VT_DIV
    } vt_state_t;

endpackage

>>> hw/rtl/wfts_mem.sv
// Task table: one synchronous RAM of entries, one write and one read port.
// Depends on wfts_pkg (entry_t).
module wfts_mem #(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [IDX_W-1:0]  waddr,
    input  wfts_pkg::entry_t  wdata,
    input  logic              re,
    input  logic [IDX_W-1:0]  raddr,
    output wfts_pkg::entry_t  rdata
);
    import wfts_pkg::*;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/wfts_vtime.sv
// Virtual time unit: (runtime * sum) mod 2^64 / weight.
// Two 32-bit partial products, then a radix-4 restoring divide. Uses wfts_pkg.
module wfts_vtime #(
    parameter int SUM_W = 11
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [wfts_pkg::RT_W-1:0]   runtime,
    input  logic [SUM_W-1:0]            psum,
    input  logic [wfts_pkg::PRIO_W-1:0] weight,
    output logic                        done,
    output logic [wfts_pkg::RT_W-1:0]   vtime
);
    import wfts_pkg::*;

    localparam int PP_W = 32 + SUM_W;

    vt_state_t         state_reg, state_next;
    logic [RT_W-1:0]   rt_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [PRIO_W-1:0] w_reg;
    logic [PP_W-1:0]   pp_lo_reg;
    logic [PP_W-1:0]   pp;
    logic [RT_W-1:0]   dvd_reg, dvd_next;
    logic [PRIO_W-1:0] rem_reg, rem_next;
    logic [4:0]        cnt_reg;
    logic              done_reg;

    // shared 32 x SUM_W multiplier
    assign pp = PP_W'((state_reg == VT_MUL_LO ? rt_reg[31:0] : rt_reg[63:32]) * sum_reg);

    // two restoring steps per cycle
    always_comb begin
        logic [PRIO_W:0] t;
        logic [RT_W-1:0] d;
        logic [PRIO_W-1:0] r;
        d = dvd_reg;
        r = rem_reg;
        for (int i = 0; i < 2; i++) begin
            t = {r, d[RT_W-1]};
            if (t >= {1'b0, w_reg}) begin
                r = PRIO_W'(t - {1'b0, w_reg});
                d = {d[RT_W-2:0], 1'b1};
            end else begin
                r = t[PRIO_W-1:0];
                d = {d[RT_W-2:0], 1'b0};
            end
        end
        dvd_next = d;
        rem_next = r;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            VT_IDLE:   if (start) state_next = VT_MUL_LO;
            VT_MUL_LO: state_next = VT_MUL_HI;
            VT_MUL_HI: state_next = VT_DIV;
            VT_DIV:    if (cnt_reg == 5'd31) state_next = VT_IDLE;
            default:   state_next = VT_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= VT_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == VT_DIV) && (cnt_reg == 5'd31);
        end
        case (state_reg)
            VT_IDLE: begin
                rt_reg  <= runtime;
                sum_reg <= psum;
                w_reg   <= (weight == '0) ? PRIO_W'(1) : weight;
                cnt_reg <= '0;
            end
            VT_MUL_LO: pp_lo_reg <= pp;
            VT_MUL_HI: begin
                dvd_reg <= RT_W'(pp_lo_reg) + {pp[31:0], 32'b0};
                rem_reg <= '0;
            end
            VT_DIV: begin
                dvd_reg <= dvd_next;
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg + 5'd1;
            end
            default: ;
        endcase
    end

    assign done  = done_reg;
    assign vtime = dvd_reg;

endmodule

>>> hw/rtl/weighted_fair_task_scheduler_top.sv
// Top level of the weighted fair task scheduler: control FSM, counters, result register.
// Depends on wfts_pkg, wfts_mem, wfts_vtime.
//
//  channel | dir | tuser              | tdata
//  s_      | in  | [2:0] operation    | [5:0] task_id, [13:6] priority_req,
//          |     |                    | [45:14] elapsed_ticks
//  m_      | out | [2:0] status       | [5:0] task_id_res
//
// Per transaction: create and unknown ops go from dispatch to the result; charge
// and kill with a valid id add a table read and, if the entry allows, a write;
// shutdown reads and retires each created task in turn; schedule reads each created
// task and runs each ready one through the virtual time unit (low and high multiply,
// then the divide), one task at a time over the single table read port.
// One transaction is worked on at a time; s_tready is high only in idle.
// A new transaction is taken while the previous result waits on m_tready.
// Reset is synchronous on aresetn; the table needs no clearing pass, since
// entries at or beyond the created count are treated as unused.
module weighted_fair_task_scheduler_top #(
    parameter int TASK_SLOTS   = wfts_pkg::TASK_SLOTS_DEF,
    parameter int MAX_PRIORITY = wfts_pkg::MAX_PRIORITY_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // task_id, priority_req, elapsed_ticks
    input  logic [2:0]  s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // task_id_res
    output logic [2:0]  m_tuser    // status
);
    import wfts_pkg::*;

    localparam int IDX_W  = $clog2(TASK_SLOTS);
    localparam int CNT_W  = $clog2(TASK_SLOTS + 1);
    localparam int SUM_W  = $clog2(TASK_SLOTS * MAX_PRIORITY + 1);
    localparam int CMP_W  = (CNT_W > ID_W) ? CNT_W : ID_W;

    state_t              state_reg, state_next;
    logic [OP_W-1:0]     op_reg;
    logic [ID_W-1:0]     id_reg;
    logic [PRIO_W-1:0]   prio_reg;
    logic [TICKS_W-1:0]  ticks_reg;
    logic [CNT_W-1:0]    created_reg, created_next;
    logic [CNT_W-1:0]    alive_reg, alive_next;
    logic [SUM_W-1:0]    psum_reg, psum_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic                found_reg, found_next;
    logic [RT_W-1:0]     best_reg, best_next;
    logic [IDX_W-1:0]    best_id_reg, best_id_next;
    res_t                res_reg, res_next;
    logic [ID_W-1:0]     res_id_reg, res_id_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [2:0]          m_tuser_reg;
    logic [7:0]          m_tdata_reg;

    logic                accept, out_load;
    logic                bad_prio, full, id_bad, scan_end;
    logic                mem_we, mem_re;
    logic [IDX_W-1:0]    mem_waddr, mem_raddr;
    entry_t              mem_wdata, mem_rdata;
    logic                vt_start, vt_done;
    logic [RT_W-1:0]     vt_val;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_FIN) && (!m_tvalid_reg || m_tready);

    assign bad_prio = (prio_reg == '0) || (prio_reg > PRIO_W'(MAX_PRIORITY));
    assign full     = (created_reg == CNT_W'(TASK_SLOTS));
    assign id_bad   = (CMP_W'(id_reg) >= CMP_W'(created_reg));
    assign scan_end = (idx_reg == created_reg);

    wfts_mem #(.DEPTH(TASK_SLOTS), .IDX_W(IDX_W)) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    wfts_vtime #(.SUM_W(SUM_W)) u_vtime (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (vt_start),
        .runtime (mem_rdata.runtime),
        .psum    (psum_reg),
        .weight  (mem_rdata.prio),
        .done    (vt_done),
        .vtime   (vt_val)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_DISPATCH;
            ST_DISPATCH: begin
                case (op_reg)
                    OP_SCHEDULE: state_next = ST_SC_RD;
                    OP_SHUTDOWN: state_next = ST_SH_RD;
                    OP_CHARGE,
                    OP_KILL:     state_next = id_bad ? ST_FIN : ST_ENT_EXEC;
                    default:     state_next = ST_FIN;
                endcase
            end
            ST_ENT_EXEC: state_next = ST_FIN;
            ST_SH_RD:    state_next = scan_end ? ST_FIN : ST_SH_EXEC;
            ST_SH_EXEC:  state_next = ST_SH_RD;
            ST_SC_RD:    state_next = scan_end ? ST_FIN : ST_SC_CHK;
            ST_SC_CHK:   state_next = (mem_rdata.st == ENT_READY) ? ST_SC_WAIT : ST_SC_RD;
            ST_SC_WAIT:  if (vt_done) state_next = ST_SC_RD;
            ST_FIN:      if (out_load) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath and table access
    always_comb begin
        created_next = created_reg;
        alive_next   = alive_reg;
        psum_next    = psum_reg;
        idx_next     = idx_reg;
        found_next   = found_reg;
        best_next    = best_reg;
        best_id_next = best_id_reg;
        res_next     = res_reg;
        res_id_next  = res_id_reg;
        mem_we       = 1'b0;
        mem_waddr    = id_reg[IDX_W-1:0];
        mem_wdata    = mem_rdata;
        mem_re       = 1'b0;
        mem_raddr    = id_reg[IDX_W-1:0];
        vt_start     = 1'b0;
        case (state_reg)
            ST_DISPATCH: begin
                res_next    = RES_OK;
                res_id_next = '0;
                idx_next    = '0;
                found_next  = 1'b0;
                case (op_reg)
                    OP_CREATE: begin
                        if (bad_prio) begin
                            res_next = RES_BAD_PRIO;
                        end else if (full) begin
                            res_next = RES_FULL;
                        end else begin
                            mem_we            = 1'b1;
                            mem_waddr         = created_reg[IDX_W-1:0];
                            mem_wdata.st      = ENT_READY;
                            mem_wdata.prio    = prio_reg;
                            mem_wdata.runtime = '0;
                            res_id_next       = ID_W'(created_reg);
                            created_next      = created_reg + CNT_W'(1);
                            alive_next        = alive_reg + CNT_W'(1);
                            psum_next         = psum_reg + SUM_W'(prio_reg);
                        end
                    end
                    OP_CHARGE,
                    OP_KILL: begin
                        if (id_bad) begin
                            res_next = RES_BAD_ID;
                        end else begin
                            mem_re = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            ST_ENT_EXEC: begin
                if (op_reg == OP_CHARGE) begin
                    if (mem_rdata.st != ENT_READY) begin
                        res_next = RES_BAD_ID;
                    end else begin
                        mem_we            = 1'b1;
                        mem_wdata.runtime = mem_rdata.runtime + RT_W'(ticks_reg);
                    end
                end else begin
                    if (mem_rdata.st == ENT_UNUSED) begin
                        res_next = RES_BAD_ID;
                    end else if (mem_rdata.st == ENT_READY) begin
                        mem_we       = 1'b1;
                        mem_wdata.st = ENT_ZOMBIE;
                        alive_next   = alive_reg - CNT_W'(1);
                        psum_next    = psum_reg - SUM_W'(mem_rdata.prio);
                    end
                end
            end
            ST_SH_RD,
            ST_SC_RD: begin
                mem_raddr = idx_reg[IDX_W-1:0];
                mem_re    = !scan_end;
                if (scan_end && state_reg == ST_SC_RD) begin
                    res_next    = found_reg ? RES_OK : RES_NONE;
                    res_id_next = found_reg ? ID_W'(best_id_reg) : '0;
                end
            end
            ST_SH_EXEC: begin
                mem_waddr = idx_reg[IDX_W-1:0];
                if (mem_rdata.st == ENT_READY) begin
                    mem_we       = 1'b1;
                    mem_wdata.st = ENT_ZOMBIE;
                    alive_next   = alive_reg - CNT_W'(1);
                    psum_next    = psum_reg - SUM_W'(mem_rdata.prio);
                end
                idx_next = idx_reg + CNT_W'(1);
            end
            ST_SC_CHK: begin
                if (mem_rdata.st == ENT_READY) begin
                    vt_start = 1'b1;
                end else begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            ST_SC_WAIT: begin
                if (vt_done) begin
                    // strict less-than keeps the lower id on a tie
                    if (!found_reg || vt_val < best_reg) begin
                        found_next   = 1'b1;
                        best_next    = vt_val;
                        best_id_next = idx_reg[IDX_W-1:0];
                    end
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            created_reg  <= '0;
            alive_reg    <= '0;
            psum_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            created_reg  <= created_next;
            alive_reg    <= alive_next;
            psum_reg     <= psum_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        if (accept) begin
            op_reg    <= s_tuser;
            id_reg    <= s_tdata[5:0];
            prio_reg  <= s_tdata[13:6];
            ticks_reg <= s_tdata[45:14];
        end
        idx_reg     <= idx_next;
        found_reg   <= found_next;
        best_reg    <= best_next;
        best_id_reg <= best_id_next;
        res_reg     <= res_next;
        res_id_reg  <= res_id_next;
        if (out_load) begin
            m_tuser_reg <= res_reg;
            m_tdata_reg <= 8'(res_id_reg);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> hw/rtl/wfts_chk.sv
// Port-level checker for the weighted fair task scheduler, bound to the top level.
// Depends on wfts_pkg (result codes).
module wfts_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic [2:0]  m_tuser
);
    import wfts_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transaction taken while busy");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == RES_OK || m_tuser == RES_BAD_PRIO ||
                      m_tuser == RES_FULL || m_tuser == RES_BAD_ID ||
                      m_tuser == RES_NONE))
        else $error("undefined status code");

    a_err_zero_id: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != RES_OK |-> m_tdata == 8'd0)
        else $error("nonzero id on error");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind weighted_fair_task_scheduler_top wfts_chk u_wfts_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> sim/weighted_fair_task_scheduler_top_tb.sv
// Testbench for weighted_fair_task_scheduler_top: directed and random task operations,
// results checked against a behavioral scheduler model. Depends on wfts_pkg and the RTL.
module weighted_fair_task_scheduler_top_tb;
    import wfts_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS    = TASK_SLOTS_DEF;
    localparam int PRIO_MAX = MAX_PRIORITY_DEF;
    localparam int WDOG_LIMIT = 400000;

    typedef struct packed {
        logic [2:0]  op;
        logic [5:0]  id;
        logic [7:0]  prio;
        logic [31:0] ticks;
    } cmd_t;

    typedef struct packed {
        logic [2:0] status;
        logic [5:0] id;
    } reply_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [2:0]  m_tuser;

    weighted_fair_task_scheduler_top dut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Shadow scheduler state
    ent_st_t     sh_st [SLOTS];
    logic [7:0]  sh_prio [SLOTS];
    logic [63:0] sh_rt [SLOTS];
    int          sh_created;
    logic [13:0] sh_psum;

    cmd_t   cmd_q [$];
    reply_t reply_q [$];
    int     errors = 0;
    int     sent = 0;
    bit     hold = 1'b0;     // sender pause until queue drains
    bit     stim_done = 1'b0;
    int     wdog = 0;

    function automatic void retire(int t);
        if (sh_st[t] == ENT_READY) begin
            sh_st[t] = ENT_ZOMBIE;
            sh_psum  = sh_psum - 14'(sh_prio[t]);
        end
    endfunction

    // Model one transaction, return the reply it should produce
    function automatic reply_t scheduler_step(cmd_t c);
        reply_t r;
        logic [63:0] vt, best;
        bit found;
        r = '0;
        case (c.op)
            OP_CREATE: begin
                if (c.prio == 0 || c.prio > PRIO_MAX) r.status = RES_BAD_PRIO;
                else if (sh_created >= SLOTS) r.status = RES_FULL;
                else begin
                    sh_st[sh_created]   = ENT_READY;
                    sh_prio[sh_created] = c.prio;
                    sh_rt[sh_created]   = '0;
                    sh_psum = sh_psum + 14'(c.prio);
                    r.id = 6'(sh_created);
                    sh_created++;
                end
            end
            OP_SCHEDULE: begin
                found = 1'b0;
                best  = '0;
                for (int t = 0; t < sh_created; t++) begin
                    if (sh_st[t] == ENT_READY) begin
                        vt = (sh_rt[t] * 64'(sh_psum)) / 64'(sh_prio[t]);
                        if (!found || vt < best) begin
                            found = 1'b1;
                            best  = vt;
                            r.id  = 6'(t);
                        end
                    end
                end
                if (!found) r.status = RES_NONE;
            end
            OP_CHARGE: begin
                if (c.id >= sh_created || sh_st[c.id] != ENT_READY) r.status = RES_BAD_ID;
                else sh_rt[c.id] = sh_rt[c.id] + 64'(c.ticks);
            end
            OP_KILL: begin
                if (c.id >= sh_created) r.status = RES_BAD_ID;
                else retire(c.id);
            end
            OP_SHUTDOWN: for (int t = 0; t < sh_created; t++) retire(t);
            default: ;
        endcase
        return r;
    endfunction

    function automatic cmd_t mk(logic [2:0] op, logic [5:0] id, logic [7:0] p,
                                logic [31:0] tk);
        cmd_t c;
        c.op = op; c.id = id; c.prio = p; c.ticks = tk;
        return c;
    endfunction

    // Random ticks: small half the time so that virtual times differ, else huge
    function automatic logic [31:0] rnd_ticks();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'hFFFF_FFFF;
            default: return 32'($urandom_range(0, 1000));
        endcase
    endfunction

    // Driver: one transaction per handshake, random gap drawn per item
    int gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                reply_q.push_back(scheduler_step(cmd_q.pop_front()));
                sent++;
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            end
            if (s_tvalid && !s_tready) begin
                // holding current transaction
            end else if (cmd_q.size() > 0 && !hold && gap == 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {2'b00, cmd_q[0].ticks, cmd_q[0].prio, cmd_q[0].id};
                s_tuser  <= cmd_q[0].op;
            end else begin
                s_tvalid <= 1'b0;
                if (gap > 0) gap--;
            end
        end
    end

    // Monitor: random stall per result, compare with oldest expectation
    int stall = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (reply_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result st=%0d id=%0d",
                                               m_tuser, m_tdata[5:0]);
                end else begin
                    reply_t e;
                    e = reply_q.pop_front();
                    if (m_tuser !== e.status || m_tdata !== {2'b00, e.id}) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp st=%0d id=%0d, got st=%0d data=%0d",
                                     e.status, e.id, m_tuser, m_tdata);
                    end
                end
                stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            end
            if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else m_tready <= 1'b1;
        end
    end

    // Watchdog: cycles with no transaction on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) wdog <= 0;
        else wdog <= wdog + 1;
        if (wdog >= WDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        logic [2:0] op;
        for (int t = 0; t < SLOTS; t++) begin
            sh_st[t] = ENT_UNUSED; sh_prio[t] = '0; sh_rt[t] = '0;
        end
        sh_created = 0;
        sh_psum = '0;

        // Directed part: empty table, bad weights, edge ticks, kills, ties
        cmd_q.push_back(mk(OP_SCHEDULE, 0, 0, 0));
        cmd_q.push_back(mk(OP_CHARGE, 0, 0, 5));
        cmd_q.push_back(mk(OP_KILL, 63, 0, 0));
        cmd_q.push_back(mk(OP_CREATE, 0, 0, 0));
        cmd_q.push_back(mk(OP_CREATE, 0, 255, 0));
        cmd_q.push_back(mk(OP_CREATE, 0, 8'(PRIO_MAX + 1), 0));
        cmd_q.push_back(mk(OP_CREATE, 63, 8'(PRIO_MAX), 32'hFFFF_FFFF));
        cmd_q.push_back(mk(OP_CREATE, 0, 1, 0));
        cmd_q.push_back(mk(OP_SCHEDULE, 0, 0, 0));
        cmd_q.push_back(mk(OP_CHARGE, 0, 0, 32'hFFFF_FFFF));
        cmd_q.push_back(mk(OP_SCHEDULE, 0, 0, 0));
        cmd_q.push_back(mk(OP_CHARGE, 2, 0, 1));
        cmd_q.push_back(mk(OP_CHARGE, 63, 0, 1));
        cmd_q.push_back(mk(OP_KILL, 1, 0, 0));
        cmd_q.push_back(mk(OP_KILL, 1, 0, 0));
        cmd_q.push_back(mk(OP_CHARGE, 1, 0, 3));
        cmd_q.push_back(mk(OP_SCHEDULE, 0, 0, 0));
        cmd_q.push_back(mk(3'd5, 7, 9, 11));
        cmd_q.push_back(mk(3'd7, 63, 255, 32'hFFFF_FFFF));
        cmd_q.push_back(mk(OP_SHUTDOWN, 0, 0, 0));
        cmd_q.push_back(mk(OP_SCHEDULE, 0, 0, 0));
        cmd_q.push_back(mk(OP_KILL, 0, 0, 0));

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Pause the sender until every directed result is back
        wait (cmd_q.size() == 0);
        @(posedge aclk);
        hold <= 1'b1;
        wait (reply_q.size() == 0 && !s_tvalid);
        @(posedge aclk);
        hold <= 1'b0;

        // Random part: mixed work on a partly filled table
        for (int i = 0; i < 40; i++) begin
            case ($urandom_range(0, 15))
                0, 1, 2, 3, 4: op = OP_CREATE;
                5, 6, 7:       op = OP_SCHEDULE;
                8, 9, 10, 11:  op = OP_CHARGE;
                12, 13:        op = OP_KILL;
                14:            op = ($urandom_range(0, 9) == 0) ? OP_SHUTDOWN : OP_SCHEDULE;
                default:       op = 3'($urandom_range(5, 7));
            endcase
            cmd_q.push_back(mk(op, 6'($urandom()),
                               ($urandom_range(0, 7) == 0) ? 8'($urandom())
                                                           : 8'($urandom_range(1, PRIO_MAX)),
                               rnd_ticks()));
        end
        // Fill the table to the top and past its end
        for (int i = 0; i < 70; i++) cmd_q.push_back(mk(OP_CREATE, 0, 8'($urandom_range(1, PRIO_MAX)), 0));
        for (int i = 0; i < 6; i++) begin
            cmd_q.push_back(mk(OP_CHARGE, 6'($urandom_range(40, 63)), 0, rnd_ticks()));
            cmd_q.push_back(mk(OP_SCHEDULE, 0, 0, 0));
        end

        wait (cmd_q.size() == 0 && !s_tvalid);
        wait (reply_q.size() == 0);
        repeat (50) @(posedge aclk);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
